[hw/rtl/stt_pkg.sv]
// stt_pkg: shared types and defaults for the software timer table
// command codes, per-slot event flags and parameter defaults
// no dependencies
`default_nettype none

package stt_pkg;

    localparam int SLOT_COUNT_DEF = 10;
    localparam int TAG_BITS_DEF   = 8;
    localparam int COUNT_BITS_DEF = 32;

    // command codes on the func field
    typedef enum logic [2:0] {
        FUNC_TICK      = 3'd0,
        FUNC_START_ONE = 3'd1,
        FUNC_START_PER = 3'd2,
        FUNC_STOP      = 3'd3,
        FUNC_RESTART   = 3'd4
    } t_func;

    // what the slot unit saw on the slot at the head of the ring
    typedef struct packed {
        logic expire;
        logic hit;
    } t_slot_evt;

endpackage

`default_nettype wire

[hw/rtl/software_timer_table_core.sv]
// software_timer_table_core: table of timer slots kept in a rotating ring of cells
// depends on stt_pkg, stt_cell and stt_slot_unit
`default_nettype none

// channel   direction  handshake            payload
// request   in         i_valid / o_stall    i_func, i_owner_tag, i_period_ticks
// result    out        o_valid / i_stall    o_kind, o_found, o_fired_tag,
//                                           o_fired_slot, o_last
//
// a request is accepted, then the ring rotates once per slot, and a flush step
// sends the last result if there is one. the rotation is the limit: one slot
// per cycle passes the shared slot unit unless the walk is held. a tick gives
// one result per expired slot, each held back until the next expiry or the flush
// so that the final one can carry o_last; a stalled output holds the walk when a
// held expiry has to be pushed out, and holds the flush.
// synchronous reset clears every slot at once and empties the output.

module software_timer_table_core
    import stt_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int TAG_BITS   = TAG_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_func,
    input  wire logic [7:0]  i_owner_tag,
    input  wire logic [31:0] i_period_ticks,
    // result channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_kind,
    output logic             o_found,
    output logic [7:0]       o_fired_tag,
    output logic [3:0]       o_fired_slot,
    output logic             o_last
);

    localparam int SLOT_BITS = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [SLOT_BITS-1:0] LAST_STEP = SLOT_BITS'(SLOT_COUNT - 1);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_WALK  = 3'b010,
        ST_FLUSH = 3'b100
    } t_state;

    // control
    t_state                r_state, n_state;
    logic [SLOT_BITS-1:0]  r_step,  n_step;
    logic                  r_hit,   n_hit;
    logic [SLOT_BITS-1:0]  r_hit_slot, n_hit_slot;

    // latched request
    t_func                 r_func;
    logic [TAG_BITS-1:0]   r_tag;
    logic [COUNT_BITS-1:0] r_period;

    // expiry held back until the next expiry or the flush so the last one can be marked
    logic                  r_pend_valid, n_pend_valid;
    logic [TAG_BITS-1:0]   r_pend_tag,   n_pend_tag;
    logic [SLOT_BITS-1:0]  r_pend_slot,  n_pend_slot;

    // output register
    logic                  r_out_valid, n_out_valid;
    logic                  r_out_kind,  n_out_kind;
    logic                  r_out_found, n_out_found;
    logic [7:0]            r_out_tag,   n_out_tag;
    logic [3:0]            r_out_slot,  n_out_slot;
    logic                  r_out_last,  n_out_last;

    // ring wiring
    logic [TAG_BITS-1:0]   w_owner     [SLOT_COUNT];
    logic [COUNT_BITS-1:0] w_period    [SLOT_COUNT];
    logic [COUNT_BITS-1:0] w_remaining [SLOT_COUNT];
    logic                  w_periodic  [SLOT_COUNT];

    logic [TAG_BITS-1:0]   w_upd_owner;
    logic [COUNT_BITS-1:0] w_upd_period;
    logic [COUNT_BITS-1:0] w_upd_remaining;
    logic                  w_upd_periodic;
    t_slot_evt             w_evt;

    logic w_accept;
    logic w_out_free;
    logic w_shift;

    assign w_accept   = i_valid && !o_stall;
    assign w_out_free = !r_out_valid || !i_stall;

    // the slot at cell 0 is processed; everything moves one cell toward the head
    genvar g;
    generate
        for (g = 0; g < SLOT_COUNT; g++) begin : g_ring
            logic [TAG_BITS-1:0]   w_in_owner;
            logic [COUNT_BITS-1:0] w_in_period;
            logic [COUNT_BITS-1:0] w_in_remaining;
            logic                  w_in_periodic;

            if (g == SLOT_COUNT - 1) begin : g_tail
                assign w_in_owner     = w_upd_owner;
                assign w_in_period    = w_upd_period;
                assign w_in_remaining = w_upd_remaining;
                assign w_in_periodic  = w_upd_periodic;
            end else begin : g_mid
                assign w_in_owner     = w_owner[g+1];
                assign w_in_period    = w_period[g+1];
                assign w_in_remaining = w_remaining[g+1];
                assign w_in_periodic  = w_periodic[g+1];
            end

            stt_cell #(
                .TAG_BITS   (TAG_BITS),
                .COUNT_BITS (COUNT_BITS)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_shift     (w_shift),
                .i_owner     (w_in_owner),
                .i_period    (w_in_period),
                .i_remaining (w_in_remaining),
                .i_periodic  (w_in_periodic),
                .o_owner     (w_owner[g]),
                .o_period    (w_period[g]),
                .o_remaining (w_remaining[g]),
                .o_periodic  (w_periodic[g])
            );
        end
    endgenerate

    stt_slot_unit #(
        .TAG_BITS   (TAG_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_slot_unit (
        .i_func       (r_func),
        .i_tag        (r_tag),
        .i_cmd_period (r_period),
        .i_armed      (!r_hit),
        .i_owner      (w_owner[0]),
        .i_period     (w_period[0]),
        .i_remaining  (w_remaining[0]),
        .i_periodic   (w_periodic[0]),
        .o_owner      (w_upd_owner),
        .o_period     (w_upd_period),
        .o_remaining  (w_upd_remaining),
        .o_periodic   (w_upd_periodic),
        .o_evt        (w_evt)
    );

    // walk steps unless an expiry would push out the held one while the output is full
    assign w_shift = (r_state == ST_WALK)
                  && (!(w_evt.expire && r_pend_valid) || w_out_free);

    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        n_hit        = r_hit;
        n_hit_slot   = r_hit_slot;
        n_pend_valid = r_pend_valid;
        n_pend_tag   = r_pend_tag;
        n_pend_slot  = r_pend_slot;
        // output drains when taken
        n_out_valid  = r_out_valid && i_stall;
        n_out_kind   = r_out_kind;
        n_out_found  = r_out_found;
        n_out_tag    = r_out_tag;
        n_out_slot   = r_out_slot;
        n_out_last   = r_out_last;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state      = ST_WALK;
                    n_step       = '0;
                    n_hit        = 1'b0;
                    n_hit_slot   = '0;
                    n_pend_valid = 1'b0;
                end
            end
            ST_WALK: begin
                if (w_shift) begin
                    if (w_evt.expire) begin
                        if (r_pend_valid) begin
                            // earlier expiry goes out, not the final one
                            n_out_valid = 1'b1;
                            n_out_kind  = 1'b1;
                            n_out_found = 1'b0;
                            n_out_tag   = 8'(r_pend_tag);
                            n_out_slot  = 4'(r_pend_slot);
                            n_out_last  = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_tag   = w_owner[0];
                        n_pend_slot  = r_step;
                    end
                    if (w_evt.hit) begin
                        n_hit      = 1'b1;
                        n_hit_slot = r_step;
                    end
                    if (r_step == LAST_STEP) begin
                        n_state = ST_FLUSH;
                        n_step  = '0;
                    end else begin
                        n_step = r_step + SLOT_BITS'(1);
                    end
                end
            end
            ST_FLUSH: begin
                if (r_func == FUNC_TICK) begin
                    if (!r_pend_valid) begin
                        // tick with nothing expired gives no result
                        n_state = ST_IDLE;
                    end else if (w_out_free) begin
                        n_out_valid  = 1'b1;
                        n_out_kind   = 1'b1;
                        n_out_found  = 1'b0;
                        n_out_tag    = 8'(r_pend_tag);
                        n_out_slot   = 4'(r_pend_slot);
                        n_out_last   = 1'b1;
                        n_pend_valid = 1'b0;
                        n_state      = ST_IDLE;
                    end
                end else if (w_out_free) begin
                    // command reply, slot zero when nothing matched
                    n_out_valid = 1'b1;
                    n_out_kind  = 1'b0;
                    n_out_found = r_hit;
                    n_out_tag   = '0;
                    n_out_slot  = r_hit ? 4'(r_hit_slot) : '0;
                    n_out_last  = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_step       <= '0;
            r_hit        <= 1'b0;
            r_hit_slot   <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_step       <= n_step;
            r_hit        <= n_hit;
            r_hit_slot   <= n_hit_slot;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func   <= t_func'(i_func);
            r_tag    <= TAG_BITS'(i_owner_tag);
            r_period <= COUNT_BITS'(i_period_ticks);
        end
        r_pend_tag  <= n_pend_tag;
        r_pend_slot <= n_pend_slot;
        r_out_kind  <= n_out_kind;
        r_out_found <= n_out_found;
        r_out_tag   <= n_out_tag;
        r_out_slot  <= n_out_slot;
        r_out_last  <= n_out_last;
    end

    assign o_stall      = (r_state != ST_IDLE);
    assign o_valid      = r_out_valid;
    assign o_kind       = r_out_kind;
    assign o_found      = r_out_found;
    assign o_fired_tag  = r_out_tag;
    assign o_fired_slot = r_out_slot;
    assign o_last       = r_out_last;

    // an idle block holds no unsent expiry
    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend_valid)
        else $error("held expiry left over in idle");

    // walk position stays inside the table
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= LAST_STEP)
        else $error("walk step beyond last slot");

    // a command reply is always the only and final result
    a_reply_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_kind) |-> o_last)
        else $error("command reply without last mark");

    // a reply that found nothing points at slot zero
    a_miss_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_kind && !o_found) |-> (o_fired_slot == '0))
        else $error("missed command reply with nonzero slot");

    // expiry events never carry the found flag
    a_expiry_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind) |-> !o_found)
        else $error("expiry event with found set");

endmodule

`default_nettype wire

[hw/rtl/stt_cell.sv]
// stt_cell: one timer slot register stage of the rotating ring
// depends on stt_pkg for parameter defaults
`default_nettype none

module stt_cell
    import stt_pkg::*;
#(
    parameter int TAG_BITS   = TAG_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_shift,
    input  wire logic [TAG_BITS-1:0]   i_owner,
    input  wire logic [COUNT_BITS-1:0] i_period,
    input  wire logic [COUNT_BITS-1:0] i_remaining,
    input  wire logic                  i_periodic,
    output logic      [TAG_BITS-1:0]   o_owner,
    output logic      [COUNT_BITS-1:0] o_period,
    output logic      [COUNT_BITS-1:0] o_remaining,
    output logic                       o_periodic
);

    logic [TAG_BITS-1:0]   r_owner;
    logic [COUNT_BITS-1:0] r_period;
    logic [COUNT_BITS-1:0] r_remaining;
    logic                  r_periodic;

    // slot state is architectural, so reset clears it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owner     <= '0;
            r_period    <= '0;
            r_remaining <= '0;
            r_periodic  <= 1'b0;
        end else if (i_shift) begin
            r_owner     <= i_owner;
            r_period    <= i_period;
            r_remaining <= i_remaining;
            r_periodic  <= i_periodic;
        end
    end

    assign o_owner     = r_owner;
    assign o_period    = r_period;
    assign o_remaining = r_remaining;
    assign o_periodic  = r_periodic;

endmodule

`default_nettype wire

[hw/rtl/stt_slot_unit.sv]
// stt_slot_unit: update of the slot leaving the head of the ring
// handles tick countdown and the claim, stop and restart commands; uses stt_pkg
`default_nettype none

module stt_slot_unit
    import stt_pkg::*;
#(
    parameter int TAG_BITS   = TAG_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire t_func                 i_func,
    input  wire logic [TAG_BITS-1:0]   i_tag,
    input  wire logic [COUNT_BITS-1:0] i_cmd_period,
    input  wire logic                  i_armed,
    input  wire logic [TAG_BITS-1:0]   i_owner,
    input  wire logic [COUNT_BITS-1:0] i_period,
    input  wire logic [COUNT_BITS-1:0] i_remaining,
    input  wire logic                  i_periodic,
    output logic      [TAG_BITS-1:0]   o_owner,
    output logic      [COUNT_BITS-1:0] o_period,
    output logic      [COUNT_BITS-1:0] o_remaining,
    output logic                       o_periodic,
    output t_slot_evt                  o_evt
);

    logic [COUNT_BITS-1:0] w_dec;
    logic                  w_tag_ok;

    assign w_dec    = i_remaining - COUNT_BITS'(1);
    assign w_tag_ok = i_armed && (i_tag != '0);

    always_comb begin
        o_owner     = i_owner;
        o_period    = i_period;
        o_remaining = i_remaining;
        o_periodic  = i_periodic;
        o_evt       = '0;
        case (i_func)
            FUNC_TICK: begin
                if (i_remaining != '0) begin
                    o_remaining = w_dec;
                    if (w_dec == '0) begin
                        o_evt.expire = 1'b1;
                        o_remaining  = i_periodic ? i_period : '0;
                    end
                end
            end
            FUNC_START_ONE, FUNC_START_PER: begin
                // claim the first free slot
                if (w_tag_ok && i_owner == '0) begin
                    o_evt.hit   = 1'b1;
                    o_owner     = i_tag;
                    o_period    = i_cmd_period;
                    o_remaining = i_cmd_period;
                    o_periodic  = (i_func == FUNC_START_PER);
                end
            end
            FUNC_STOP: begin
                if (w_tag_ok && i_owner == i_tag) begin
                    o_evt.hit   = 1'b1;
                    o_owner     = '0;
                    o_remaining = '0;
                end
            end
            FUNC_RESTART: begin
                if (w_tag_ok && i_owner == i_tag) begin
                    o_evt.hit   = 1'b1;
                    o_remaining = i_period;
                end
            end
            default: begin
                o_evt = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

[tb/tb_software_timer_table_core.sv]
// tb_software_timer_table_core: self-checking bench for the software timer table core
// drives tick and command requests, predicts replies and expiries, checks each result
// depends on stt_pkg and software_timer_table_core
`default_nettype none

module tb_software_timer_table_core;
    import stt_pkg::*;

    localparam int SLOT_COUNT = SLOT_COUNT_DEF;
    // drain wait sized from one request's walk of every slot plus accept and flush, doubled for margin
    localparam int DRAIN_CYCLES = 2 * (SLOT_COUNT + 2);
    // function codes the block must answer with a not-found reply
    localparam logic [2:0] FUNC_BAD_LO = 3'd5;
    localparam logic [2:0] FUNC_BAD_HI = 3'd7;
    // small tag pool so that stops and restarts mostly hit a live slot
    localparam int TAG_POOL = 12;

    typedef struct {
        logic [2:0]  func;
        logic [7:0]  tag;
        logic [31:0] period;
        bit          drain_first;   // hold this request until all results are back
    } timer_req_t;

    typedef struct packed {
        logic       kind;
        logic       found;
        logic [7:0] fired_tag;
        logic [3:0] fired_slot;
        logic       last;
    } timer_result_t;

    // clock, reset and block ports
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    logic [2:0]  req_func = FUNC_TICK;
    logic [7:0]  req_tag = '0;
    logic [31:0] req_period = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    logic        res_kind;
    logic        res_found;
    logic [7:0]  res_fired_tag;
    logic [3:0]  res_fired_slot;
    logic        res_last;

    // stimulus and scoreboard
    timer_req_t    queued_requests[$];
    timer_result_t expected_events[$];
    timer_req_t    driven_req;
    int            items_total = 1;
    int            accepted_count = 0;
    int            predicted_count = 0;
    int            results_seen = 0;     // written by the monitor only
    int            quiet_cycles = 0;
    int            idle_phase = 0;       // 0: sender idles less, 1: receiver idles less, 2: none
    int            error_count = 0;

    // predicted table contents
    logic [7:0]  slot_tag     [SLOT_COUNT];
    logic [31:0] slot_len     [SLOT_COUNT];
    logic [31:0] slot_left    [SLOT_COUNT];
    bit          slot_repeats [SLOT_COUNT];

    software_timer_table_core u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (req_valid),
        .o_stall        (req_stall),
        .i_func         (req_func),
        .i_owner_tag    (req_tag),
        .i_period_ticks (req_period),
        .o_valid        (res_valid),
        .i_stall        (res_stall),
        .o_kind         (res_kind),
        .o_found        (res_found),
        .o_fired_tag    (res_fired_tag),
        .o_fired_slot   (res_fired_slot),
        .o_last         (res_last)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // first slot whose owner equals tag, -1 if none (tag zero finds a free slot)
    function automatic int first_slot_owned_by(logic [7:0] tag);
        for (int s = 0; s < SLOT_COUNT; s++) begin
            if (slot_tag[s] == tag) return s;
        end
        return -1;
    endfunction

    // update the predicted table for one accepted request and queue its results
    task automatic apply_timer_request(input timer_req_t req);
        timer_result_t fired [SLOT_COUNT];
        timer_result_t reply;
        int            n_fired;
        int            hit;
        n_fired = 0;
        hit = -1;
        if (req.func == FUNC_TICK) begin
            // walk slots in index order, every running count steps down by one
            for (int s = 0; s < SLOT_COUNT; s++) begin
                if (slot_left[s] != '0) begin
                    slot_left[s] = slot_left[s] - 1;
                    if (slot_left[s] == '0) begin
                        if (slot_repeats[s]) slot_left[s] = slot_len[s];
                        fired[n_fired] = '{kind: 1'b1, found: 1'b0, fired_tag: slot_tag[s],
                                           fired_slot: 4'(s), last: 1'b0};
                        n_fired++;
                    end
                end
            end
            // a tick with nothing expiring answers with nothing at all
            for (int k = 0; k < n_fired; k++) begin
                fired[k].last = (k == n_fired - 1);
                expected_events.push_back(fired[k]);
            end
            predicted_count += n_fired;
        end else begin
            // tag zero means no owner: every command with it misses
            if (req.tag != '0) begin
                case (req.func)
                    FUNC_START_ONE, FUNC_START_PER: begin
                        hit = first_slot_owned_by('0);
                        if (hit >= 0) begin
                            slot_tag[hit]     = req.tag;
                            slot_len[hit]     = req.period;
                            slot_left[hit]    = req.period;
                            slot_repeats[hit] = (req.func == FUNC_START_PER);
                        end
                    end
                    FUNC_STOP: begin
                        hit = first_slot_owned_by(req.tag);
                        if (hit >= 0) begin
                            slot_left[hit] = '0;
                            slot_tag[hit]  = '0;
                        end
                    end
                    FUNC_RESTART: begin
                        hit = first_slot_owned_by(req.tag);
                        if (hit >= 0) slot_left[hit] = slot_len[hit];
                    end
                    default: ;  // unknown codes only get a miss reply
                endcase
            end
            reply = '{kind: 1'b0, found: (hit >= 0), fired_tag: 8'd0,
                      fired_slot: (hit >= 0) ? 4'(hit) : 4'd0, last: 1'b1};
            expected_events.push_back(reply);
            predicted_count++;
        end
    endtask

    function automatic timer_req_t make_req(logic [2:0] func, logic [7:0] tag,
                                            logic [31:0] period);
        timer_req_t r;
        r.func = func;
        r.tag = tag;
        r.period = period;
        r.drain_first = 1'b0;
        return r;
    endfunction

    // random request: mostly well-formed commands on a small tag pool, some noise
    function automatic timer_req_t random_request();
        timer_req_t  r;
        int unsigned pick;
        pick = $urandom_range(99);
        if ($urandom_range(99) < 85) r.tag = 8'($urandom_range(TAG_POOL, 1));
        else r.tag = 8'($urandom_range(255, 1));
        pick = $urandom_range(99);
        if (pick < 70) r.period = 32'($urandom_range(6, 1));
        else if (pick < 80) r.period = '0;
        else r.period = $urandom;
        r.drain_first = 1'b0;
        pick = $urandom_range(99);
        if (pick < 38) begin
            r.func = FUNC_TICK;
            r.tag = 8'($urandom_range(255));
        end else if (pick < 52) r.func = FUNC_START_ONE;
        else if (pick < 64) r.func = FUNC_START_PER;
        else if (pick < 82) r.func = FUNC_STOP;
        else if (pick < 94) r.func = FUNC_RESTART;
        else if ($urandom_range(1) == 0) begin
            r.func = 3'($urandom_range(FUNC_BAD_HI, FUNC_BAD_LO));
        end else begin
            // command without an owner
            r.func = 3'($urandom_range(FUNC_RESTART, FUNC_START_ONE));
            r.tag = '0;
        end
        return r;
    endfunction

    // driver: predicts on acceptance, then presents the next queued request
    always @(posedge clk) begin : drive_requests
        bit accepted;
        bit send;
        int idle_pct;
        if (!rst_n) begin
            req_valid <= 1'b0;
            quiet_cycles = 0;
        end else begin
            accepted = req_valid && !req_stall;
            if (accepted) begin
                apply_timer_request(driven_req);
                accepted_count++;
            end
            // count cycles with nothing in flight and nothing owed
            if (accepted || results_seen != predicted_count) quiet_cycles = 0;
            else if (!req_valid) quiet_cycles++;
            idle_phase <= (accepted_count < items_total / 3) ? 0 :
                          (accepted_count < 2 * items_total / 3) ? 1 : 2;
            if (!req_valid || accepted) begin
                idle_pct = (idle_phase == 0) ? 32 : (idle_phase == 1) ? 50 : 0;
                send = 1'b0;
                if (queued_requests.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    if (!queued_requests[0].drain_first || quiet_cycles >= DRAIN_CYCLES)
                        send = 1'b1;
                end
                if (send) begin
                    driven_req = queued_requests.pop_front();
                    req_valid  <= 1'b1;
                    req_func   <= driven_req.func;
                    req_tag    <= driven_req.tag;
                    req_period <= driven_req.period;
                end else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: mismatch on %s, expected %0h, actual %0h", $time, what, want, got);
            error_count++;
        end
    endtask

    // monitor: compare each accepted result with the oldest expectation
    always @(posedge clk) begin : check_results
        timer_result_t want;
        int            idle_pct;
        if (!rst_n) begin
            res_stall <= 1'b0;
        end else begin
            if (res_valid && !res_stall) begin
                if (expected_events.size() == 0) begin
                    // actual shown as kind, found, tag, slot, last packed together
                    $display("%0t: unexpected result, expected none, actual %0h", $time,
                             {res_kind, res_found, res_fired_tag, res_fired_slot, res_last});
                    error_count++;
                end else begin
                    want = expected_events.pop_front();
                    check_field("kind", want.kind, res_kind);
                    check_field("found", want.found, res_found);
                    check_field("fired_tag", want.fired_tag, res_fired_tag);
                    check_field("fired_slot", want.fired_slot, res_fired_slot);
                    check_field("last", want.last, res_last);
                    results_seen <= results_seen + 1;
                end
            end
            idle_pct = (idle_phase == 0) ? 50 : (idle_phase == 1) ? 32 : 0;
            res_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    initial begin
        timer_req_t r;
        for (int s = 0; s < SLOT_COUNT; s++) begin
            slot_tag[s] = '0;
            slot_len[s] = '0;
            slot_left[s] = '0;
            slot_repeats[s] = 1'b0;
        end

        // empty table, ownerless commands and unknown codes
        queued_requests.push_back(make_req(FUNC_TICK, 8'h00, 32'h0));
        queued_requests.push_back(make_req(FUNC_START_ONE, 8'h00, 32'd5));
        queued_requests.push_back(make_req(FUNC_STOP, 8'h00, 32'd0));
        queued_requests.push_back(make_req(FUNC_RESTART, 8'h00, 32'd0));
        for (int f = FUNC_BAD_LO; f <= FUNC_BAD_HI; f++)
            queued_requests.push_back(make_req(3'(f), 8'($urandom_range(255)), $urandom));
        // longest period, shortest one-shot, and a periodic zero period that never fires
        queued_requests.push_back(make_req(FUNC_START_PER, 8'hFF, 32'hFFFF_FFFF));
        queued_requests.push_back(make_req(FUNC_START_ONE, 8'h01, 32'd1));
        queued_requests.push_back(make_req(FUNC_START_PER, 8'h80, 32'd0));
        // fill the rest of the table with period one, mixed kinds
        for (int t = 2; t < SLOT_COUNT - 1; t++)
            queued_requests.push_back(make_req(t[0] ? FUNC_START_PER : FUNC_START_ONE,
                                               8'(t), 32'd1));
        // table full
        queued_requests.push_back(make_req(FUNC_START_ONE, 8'h09, 32'd3));
        // restart of a zero period slot leaves it silent
        queued_requests.push_back(make_req(FUNC_RESTART, 8'h80, 32'd0));
        // nearly every slot expires on one tick
        queued_requests.push_back(make_req(FUNC_TICK, 8'hA5, 32'hFFFF_FFFF));
        queued_requests.push_back(make_req(FUNC_STOP, 8'hFF, 32'd0));
        queued_requests.push_back(make_req(FUNC_STOP, 8'h55, 32'd0));
        queued_requests.push_back(make_req(FUNC_RESTART, 8'h55, 32'd0));
        queued_requests.push_back(make_req(FUNC_RESTART, 8'h01, 32'd0));
        // expired one-shot restarted, periodic slots fire again
        queued_requests.push_back(make_req(FUNC_TICK, 8'h5A, 32'h0));
        // duplicate tag lands in the freed lowest slot, stop hits the first match
        queued_requests.push_back(make_req(FUNC_START_ONE, 8'h01, 32'd2));
        queued_requests.push_back(make_req(FUNC_STOP, 8'h01, 32'd0));
        queued_requests.push_back(make_req(FUNC_TICK, 8'h00, 32'h0));

        // random part, with full drains at its start and halfway
        for (int n = 0; n < 300; n++) begin
            r = random_request();
            if (n == 0 || n == 150) r.drain_first = 1'b1;
            queued_requests.push_back(r);
        end
        items_total = queued_requests.size();

        // reset held from the start, then released and never asserted again
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (queued_requests.size() != 0 || req_valid) @(negedge clk);
        while (expected_events.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (expected_events.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_events.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("tb_software_timer_table_core: PASS");
        end else begin
            $display("tb_software_timer_table_core: FAIL");
        end
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("tb_software_timer_table_core: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
